// File: hw/rtl/tci_pkg.sv
// Package for the threshold crossing interpolator.
// Sizes, reset constants, codes and controller/datapath link types.
// No dependencies.
`default_nettype none

package tci_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 24;

    // product / quotient register holds |dx| * |dn|, both DATA_WIDTH+1 bits
    localparam int MAG_W  = DATA_WIDTH + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    // round(1.0e-4 * 2^FRAC_BITS)
    localparam longint unsigned THRESH_RESET_FULL =
        ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [DATA_WIDTH-1:0] THRESH_RESET = DATA_WIDTH'(THRESH_RESET_FULL);

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NEVER = 2'd1,
        STAT_FIRST = 2'd2,
        STAT_FLAT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MS_NONE  = 2'd0,
        MS_FIRST = 2'd1,
        MS_SEG   = 2'd2
    } match_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_DIV  = 2'd2,
        S_FIN  = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic mul_step;
        logic div_step;
        logic load_out;
    } tci_cmd_t;

    typedef struct packed {
        logic need_calc;
        logic mul_done;
        logic div_done;
    } tci_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/tci_in_if.sv
// Sample channel: valid/ready handshake with x, y and last mark.
// Depends on tci_pkg.
`default_nettype none

interface tci_in_if;
    import tci_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [DATA_WIDTH-1:0] y_value;
    logic                         is_last;

    modport source (output valid, output x_value, output y_value, output is_last,
                    input ready);
    modport sink   (input valid, input x_value, input y_value, input is_last,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tci_out_if.sv
// Result channel: valid/ready handshake with crossing x and status.
// Depends on tci_pkg.
`default_nettype none

interface tci_out_if;
    import tci_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] crossing_x;
    logic [1:0]                   status;

    modport source (output valid, output crossing_x, output status, input ready);
    modport sink   (input valid, input crossing_x, input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tci_ctrl.sv
// Controller FSM: handshakes, multiply/divide sequencing, result valid.
// Depends on tci_pkg.
`default_nettype none

module tci_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_last,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire tci_pkg::tci_stat_t stat,
    output tci_pkg::tci_cmd_t       cmd
);
    import tci_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;
    logic        accept;

    assign slot_free = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_last && stat.need_calc)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (stat.mul_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = slot_free;
                cmd.accept = accept;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_FIN:
            begin
                cmd.load_out = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out || (cmd.accept && in_last && !stat.need_calc))
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tci_dpath.sv
// Datapath: threshold register, stream/segment state, shift-add multiplier,
// restoring divider, saturating add and result registers. Depends on tci_pkg.
`default_nettype none

module tci_dpath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic        [tci_pkg::DATA_WIDTH-1:0] cfg_wdata,
    input  wire logic signed [tci_pkg::DATA_WIDTH-1:0] x_value,
    input  wire logic signed [tci_pkg::DATA_WIDTH-1:0] y_value,
    input  wire logic                                is_last,
    input  wire tci_pkg::tci_cmd_t                   cmd,
    output tci_pkg::tci_stat_t                       stat,
    output logic signed [tci_pkg::DATA_WIDTH-1:0]    crossing_x,
    output logic        [1:0]                        status
);
    import tci_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int SUM_W = PROD_W + 2;

    logic [W-1:0] thr_reg;
    logic [W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic         have_prev_reg, have_prev_next;
    logic [W-1:0] seg_x0_reg, seg_x0_next, seg_y0_reg, seg_y0_next;
    logic [W-1:0] seg_x1_reg, seg_x1_next, seg_y1_reg, seg_y1_next;
    match_t       match_reg, match_next;

    logic [MAG_W-1:0]  mcand_reg, mcand_next;
    logic [MAG_W-1:0]  dy_mag_reg, dy_mag_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MAG_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [W-1:0]      x0_reg, x0_next;
    logic [W-1:0]      cx_reg, cx_next;
    status_t           stat_reg, stat_next;

    logic             hit;
    logic [MAG_W-1:0] dx, dy, dn;
    logic [MAG_W-1:0] dx_mag, dy_mag, dn_mag;
    logic             flat;
    status_t          direct_stat;

    logic [MAG_W:0]    mul_sum;
    logic [MAG_W:0]    trial;
    logic [MAG_W+1:0]  diff;
    logic [PROD_W:0]   q_signed;
    logic [SUM_W-1:0]  s;
    logic [SUM_W-W:0]  s_top;

    // sample match and segment update
    always_comb
    begin
        hit            = $signed(y_value) >= $signed(thr_reg);
        seg_x0_next    = seg_x0_reg;
        seg_y0_next    = seg_y0_reg;
        seg_x1_next    = seg_x1_reg;
        seg_y1_next    = seg_y1_reg;
        match_next     = match_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        if (cmd.accept)
        begin
            if (hit && have_prev_reg)
            begin
                seg_x0_next = prev_x_reg;
                seg_y0_next = prev_y_reg;
                seg_x1_next = x_value;
                seg_y1_next = y_value;
                match_next  = MS_SEG;
            end
            else if (hit)
            begin
                match_next = MS_FIRST;
            end
            prev_x_next    = x_value;
            prev_y_next    = y_value;
            have_prev_next = 1'b1;
        end
    end

    // segment differences, exact in W+1 bits
    always_comb
    begin
        dx     = {seg_x1_next[W-1], seg_x1_next} - {seg_x0_next[W-1], seg_x0_next};
        dy     = {seg_y1_next[W-1], seg_y1_next} - {seg_y0_next[W-1], seg_y0_next};
        dn     = {thr_reg[W-1], thr_reg} - {seg_y0_next[W-1], seg_y0_next};
        dx_mag = dx[MAG_W-1] ? (~dx + 1'b1) : dx;
        dy_mag = dy[MAG_W-1] ? (~dy + 1'b1) : dy;
        dn_mag = dn[MAG_W-1] ? (~dn + 1'b1) : dn;
        flat   = (dy == '0);
        case (match_next)
            MS_NONE:  direct_stat = STAT_NEVER;
            MS_FIRST: direct_stat = STAT_FIRST;
            default:  direct_stat = STAT_FLAT;
        endcase
    end

    assign stat.need_calc = (match_next == MS_SEG) && !flat;
    assign stat.mul_done  = (cnt_reg == MUL_LAST);
    assign stat.div_done  = (cnt_reg == DIV_LAST);

    // multiply/divide iteration and result assembly
    always_comb
    begin
        mul_sum  = {1'b0, prod_reg[PROD_W-1:MAG_W]}
                 + {1'b0, (prod_reg[0] ? mcand_reg : {MAG_W{1'b0}})};
        trial    = {rem_reg, prod_reg[PROD_W-1]};
        diff     = {1'b0, trial} - {2'b00, dy_mag_reg};
        q_signed = neg_reg ? (~{1'b0, prod_reg} + 1'b1) : {1'b0, prod_reg};
        s        = {{(SUM_W-W){x0_reg[W-1]}}, x0_reg} + {q_signed[PROD_W], q_signed};
        s_top    = s[SUM_W-1:W-1];

        mcand_next  = mcand_reg;
        dy_mag_next = dy_mag_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        x0_next     = x0_reg;
        cx_next     = cx_reg;
        stat_next   = stat_reg;

        if (cmd.accept && is_last)
        begin
            mcand_next  = dx_mag;
            dy_mag_next = dy_mag;
            prod_next   = {{MAG_W{1'b0}}, dn_mag};
            rem_next    = '0;
            cnt_next    = '0;
            neg_next    = dx[MAG_W-1] ^ dy[MAG_W-1] ^ dn[MAG_W-1];
            x0_next     = seg_x0_next;
            if (!stat.need_calc)
            begin
                cx_next   = '0;
                stat_next = direct_stat;
            end
        end
        if (cmd.mul_step)
        begin
            prod_next = {mul_sum, prod_reg[MAG_W-1:1]};
            cnt_next  = stat.mul_done ? '0 : cnt_reg + 1'b1;
        end
        if (cmd.div_step)
        begin
            if (!diff[MAG_W+1])
            begin
                rem_next  = diff[MAG_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[MAG_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = stat.div_done ? '0 : cnt_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            stat_next = STAT_OK;
            if (!s[SUM_W-1] && (s_top != '0))
            begin
                cx_next = {1'b0, {(W-1){1'b1}}};
            end
            else if (s[SUM_W-1] && (s_top != '1))
            begin
                cx_next = {1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                cx_next = s[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESH_RESET;
            have_prev_reg <= 1'b0;
            match_reg     <= MS_NONE;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.accept && is_last)
            begin
                have_prev_reg <= 1'b0;
                match_reg     <= MS_NONE;
            end
            else
            begin
                have_prev_reg <= have_prev_next;
                match_reg     <= match_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        seg_x0_reg <= seg_x0_next;
        seg_y0_reg <= seg_y0_next;
        seg_x1_reg <= seg_x1_next;
        seg_y1_reg <= seg_y1_next;
        mcand_reg  <= mcand_next;
        dy_mag_reg <= dy_mag_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        x0_reg     <= x0_next;
        cx_reg     <= cx_next;
        stat_reg   <= stat_next;
    end

    assign crossing_x = cx_reg;
    assign status     = stat_reg;

endmodule

`default_nettype wire

// File: hw/rtl/threshold_crossing_interpolator.sv
// Top level of the threshold crossing interpolator.
// Depends on tci_pkg, tci_in_if, tci_out_if, tci_ctrl and tci_dpath.
//
// Samples are taken one per cycle while idle and the output slot is free. A
// sample with is_last set ends the data set and yields one result word; if
// the set never reached the threshold, reached it only at its first sample,
// or its last segment that ends at or above the threshold is flat, that word
// is ready the cycle after the sample. Otherwise the crossing is computed by
// a bit-serial shift-add multiplier followed by a restoring divider that
// shares the product register and a saturating add; no sample is taken
// meanwhile. The result sits in an output register; while it waits unaccepted
// no sample is taken, and a sample is taken again in the cycle its word is
// accepted. Stream state clears after every last sample. The user must write
// threshold via cfg_we/cfg_wdata only while idle; the block won't enforce it.
`default_nettype none

module threshold_crossing_interpolator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [tci_pkg::DATA_WIDTH-1:0] cfg_wdata,
    tci_in_if.sink                             samples,
    tci_out_if.source                          result
);
    import tci_pkg::*;

    tci_cmd_t  cmd;
    tci_stat_t stat;

    tci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_last   (samples.is_last),
        .in_ready  (samples.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tci_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .x_value    (samples.x_value),
        .y_value    (samples.y_value),
        .is_last    (samples.is_last),
        .cmd        (cmd),
        .stat       (stat),
        .crossing_x (result.crossing_x),
        .status     (result.status)
    );

endmodule

`default_nettype wire

// File: tb/sv/threshold_crossing_interpolator_checker.sv
// Checker for the threshold crossing interpolator: tracks threshold writes and
// samples, predicts each result word and compares it with the result channel.
// Depends on tci_pkg, tci_in_if and tci_out_if.
module threshold_crossing_interpolator_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tci_pkg::DATA_WIDTH-1:0] cfg_wdata,
    tci_in_if                                   samples,
    tci_out_if                                  result,
    output int                                  errors,
    output int                                  pending,
    output int                                  checked,
    output int                                  interpolated
);
    timeunit 1ns;
    timeprecision 1ps;

    import tci_pkg::*;

    localparam int WIDE_W = 2 * DATA_WIDTH + 8;
    localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) << (DATA_WIDTH - 1)) - 1;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] crossing_x;
        status_t                      status;
    } crossing_word_t;

    crossing_word_t expected_crossings[$];

    logic signed [DATA_WIDTH-1:0] threshold;
    logic signed [DATA_WIDTH-1:0] prev_x, prev_y;
    logic signed [DATA_WIDTH-1:0] seg_x0, seg_y0, seg_x1, seg_y1;
    logic                         have_prev;
    match_t                       match_st;

    function automatic void clear_set();
        prev_x    = '0;
        prev_y    = '0;
        seg_x0    = '0;
        seg_y0    = '0;
        seg_x1    = '0;
        seg_y1    = '0;
        have_prev = 1'b0;
        match_st  = MS_NONE;
    endfunction

    function automatic crossing_word_t crossing_on_segment();
        logic signed [WIDE_W-1:0] x0, x1, y0, y1, th, dx, dy, dn, quot, sum;
        crossing_word_t           word;
        x0 = seg_x0;
        x1 = seg_x1;
        y0 = seg_y0;
        y1 = seg_y1;
        th = threshold;
        dx = x1 - x0;
        dy = y1 - y0;
        dn = th - y0;
        word.crossing_x = '0;
        if (dy == 0)
        begin
            word.status = STAT_FLAT;
            return word;
        end
        // signed divide truncates toward zero
        quot = (dx * dn) / dy;
        sum  = x0 + quot;
        word.status = STAT_OK;
        if (sum > SAT_HI)
            word.crossing_x = SAT_HI[DATA_WIDTH-1:0];
        else if (sum < SAT_LO)
            word.crossing_x = SAT_LO[DATA_WIDTH-1:0];
        else
            word.crossing_x = sum[DATA_WIDTH-1:0];
        return word;
    endfunction

    function automatic void take_sample(input logic signed [DATA_WIDTH-1:0] x,
                                        input logic signed [DATA_WIDTH-1:0] y,
                                        input logic last);
        crossing_word_t word;
        if (y >= threshold)
        begin
            if (have_prev)
            begin
                seg_x0   = prev_x;
                seg_y0   = prev_y;
                seg_x1   = x;
                seg_y1   = y;
                match_st = MS_SEG;
            end
            else
            begin
                match_st = MS_FIRST;
            end
        end
        prev_x    = x;
        prev_y    = y;
        have_prev = 1'b1;
        if (!last)
            return;
        case (match_st)
            MS_NONE:  word = '{crossing_x: '0, status: STAT_NEVER};
            MS_FIRST: word = '{crossing_x: '0, status: STAT_FIRST};
            default:  word = crossing_on_segment();
        endcase
        if (word.status == STAT_OK)
            interpolated++;
        expected_crossings.push_back(word);
        clear_set();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold = THRESH_RESET;
            clear_set();
            expected_crossings.delete();
            pending = 0;
        end
        else
        begin
            crossing_word_t want;
            if (cfg_we)
                threshold = cfg_wdata;
            if (samples.valid && samples.ready)
                take_sample(samples.x_value, samples.y_value, samples.is_last);
            if (result.valid && result.ready)
            begin
                if (expected_crossings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word: crossing_x %0d status %0d",
                             $time, result.crossing_x, result.status);
                end
                else
                begin
                    want = expected_crossings.pop_front();
                    checked++;
                    if (result.crossing_x !== want.crossing_x)
                    begin
                        errors++;
                        $display("%0t: crossing_x expected %0d actual %0d",
                                 $time, want.crossing_x, result.crossing_x);
                    end
                    if (result.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, result.status);
                    end
                end
            end
            pending = expected_crossings.size();
        end
    end

endmodule

// File: tb/sv/threshold_crossing_interpolator_test.sv
// Testbench top for the threshold crossing interpolator: clock, reset,
// threshold writes, sample and result traffic with random gaps, watchdog.
// Depends on tci_pkg, tci_in_if, tci_out_if, the block and its checker.
module threshold_crossing_interpolator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tci_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 3 * DATA_WIDTH + 8;
    localparam int IDLE_LIMIT    = 5000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 250;

    localparam logic signed [DATA_WIDTH-1:0] W_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] W_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [DATA_WIDTH-1:0] cfg_wdata;

    bit sender_idle;
    bit receiver_idle;
    int holds_asked;
    int items_sent;
    int sets_sent;
    int idle_cycles;
    int errors, pending, checked, interpolated;

    logic signed [DATA_WIDTH-1:0] thresh_now;
    logic signed [DATA_WIDTH-1:0] thresh_plan[PHASES];

    tci_in_if  samples_if ();
    tci_out_if result_if ();

    threshold_crossing_interpolator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (samples_if),
        .result    (result_if)
    );

    threshold_crossing_interpolator_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .samples      (samples_if),
        .result       (result_if),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked),
        .interpolated (interpolated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (samples_if.valid && samples_if.ready) ||
            (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side; a pending hold request turns into one long stall
    initial
    begin
        int gap;
        int holds_done;
        holds_done = 0;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (holds_done != holds_asked)
            begin
                gap = HOLD_CYCLES;
                holds_done = holds_asked;
            end
            else
            begin
                gap = receiver_idle ? $urandom_range(0, 17) : 0;
            end
            if (gap != 0)
            begin
                result_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_if.ready = 1'b1;
            do @(posedge clk); while (!result_if.valid);
            @(negedge clk);
        end
    end

    // called and returns at a falling edge
    task automatic send_sample(input logic signed [DATA_WIDTH-1:0] x,
                               input logic signed [DATA_WIDTH-1:0] y,
                               input logic last);
        int gap;
        gap = sender_idle ? $urandom_range(0, 17) : 0;
        if (gap != 0)
        begin
            samples_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_if.valid   = 1'b1;
        samples_if.x_value = x;
        samples_if.y_value = y;
        samples_if.is_last = last;
        do @(posedge clk); while (!samples_if.ready);
        @(negedge clk);
        items_sent++;
        if (last)
            sets_sent++;
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0:       return W_MIN;
            1:       return W_MAX;
            2:       return '0;
            3:       return '1;
            default: return thresh_now;
        endcase
    endfunction

    task automatic send_random_set(input bit short_sets);
        int                           len;
        int                           kind;
        logic signed [DATA_WIDTH-1:0] x, y;
        if (short_sets)
            len = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(1, 12);
        kind = $urandom_range(0, 9);
        x = $urandom;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0, 1, 2, 3, 4:
                begin
                    x = x + $signed($urandom_range(0, 65536)) - 16384;
                    y = thresh_now + $signed($urandom_range(0, 4000)) - 2000;
                end
                5:
                begin
                    x = $urandom;
                    y = thresh_now + $signed($urandom_range(0, 4000)) - 2000;
                end
                6, 7:
                begin
                    x = $urandom;
                    y = $urandom;
                end
                8:
                begin
                    x = x + $signed($urandom_range(0, 255));
                    y = thresh_now + $signed($urandom_range(0, 2)) - 1;
                end
                default:
                begin
                    x = extreme_value();
                    y = extreme_value();
                end
            endcase
            send_sample(x, y, i == len - 1);
        end
    endtask

    task automatic drain();
        samples_if.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int start_items;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        samples_if.valid   = 1'b0;
        samples_if.x_value = '0;
        samples_if.y_value = '0;
        samples_if.is_last = 1'b0;
        sender_idle        = 1'b0;
        receiver_idle      = 1'b0;
        holds_asked        = 0;
        thresh_now         = THRESH_RESET;
        thresh_plan = '{32'sd0, W_MAX, W_MIN, $urandom, 32'sd1678, -32'sd5000,
                        $signed($urandom_range(0, 65535)), 32'sd1 <<< FRAC_BITS};

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed sets at the reset threshold
        send_sample(0, THRESH_RESET, 1'b1);
        send_sample(5, THRESH_RESET - 1, 1'b1);
        send_sample(0, 0, 1'b0);
        send_sample(100, 1000, 1'b0);
        send_sample(200, 2000, 1'b1);
        send_sample(10, 5000, 1'b0);
        send_sample(20, 0, 1'b1);
        send_sample(0, 9000, 1'b0);
        send_sample(16, -9000, 1'b0);
        send_sample(32, 9000, 1'b1);
        send_sample(1, 4000, 1'b0);
        send_sample(2, 4000, 1'b1);
        send_sample(0, W_MAX, 1'b0);
        send_sample(2, W_MAX - 1, 1'b1);
        send_sample(0, W_MAX, 1'b0);
        send_sample(-2, W_MAX - 1, 1'b1);
        send_sample(W_MIN, W_MIN, 1'b0);
        send_sample(W_MAX, W_MAX, 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            thresh_now = thresh_plan[p];
            cfg_we     = 1'b1;
            cfg_wdata  = thresh_now;
            @(negedge clk);
            cfg_we        = 1'b0;
            sender_idle   = p[0] && (p != 4);
            receiver_idle = p[1];
            if (p == 4)
                holds_asked++;
            start_items = items_sent;
            while (items_sent - start_items < PHASE_ITEMS)
                send_random_set(p == 4 && items_sent - start_items < 60);
            drain();
        end

        $display("Sent %0d samples in %0d data sets over %0d threshold values.",
                 items_sent, sets_sent, PHASES + 1);
        $display("Checked %0d result words, %0d of them interpolated crossings.",
                 checked, interpolated);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: threshold_crossing_interpolator.f
hw/rtl/tci_pkg.sv
hw/rtl/tci_in_if.sv
hw/rtl/tci_out_if.sv
hw/rtl/tci_ctrl.sv
hw/rtl/tci_dpath.sv
hw/rtl/threshold_crossing_interpolator.sv
tb/sv/threshold_crossing_interpolator_checker.sv
tb/sv/threshold_crossing_interpolator_test.sv
